@@ rtl/core/tccu_pkg.sv @@
// Shared types, codes and constants for the text console cursor engine.
package tccu_pkg;

  localparam logic       OP_WRITE = 1'b0;
  localparam logic       OP_CLEAR = 1'b1;

  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_SPACE     = 8'd32;

  localparam logic [1:0] ACT_DRAW   = 2'd0;
  localparam logic [1:0] ACT_SCROLL = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;
  localparam logic [1:0] ACT_NONE   = 2'd3;

  localparam logic [7:0] REG_COLUMNS  = 8'd0;
  localparam logic [7:0] REG_ROWS     = 8'd1;
  localparam logic [7:0] REG_FG_COLOR = 8'd2;
  localparam logic [7:0] REG_BG_COLOR = 8'd3;

  localparam logic [7:0] COLUMNS_RESET  = 8'd80;
  localparam logic [7:0] ROWS_RESET     = 8'd25;
  localparam logic [3:0] FG_COLOR_RESET = 4'd15;
  localparam logic [3:0] BG_COLOR_RESET = 4'd0;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [7:0] columns;
    logic [7:0] rows;
    logic [3:0] fg_color;
    logic [3:0] bg_color;
  } cfg_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] col;
    logic [7:0] row;
    logic [7:0] glyph;
    logic [3:0] glyph_fg;
    logic [3:0] glyph_bg;
    logic       accepted;
    logic       last;
  } result_t;

  // Up to two words per character, pushed into the result queue together.
  typedef struct packed {
    logic    push;
    logic    two;
    result_t first;
    result_t second;
  } step_out_t;

endpackage

@@ rtl/core/text_console_cursor_engine_unit.sv @@
// A request word is registered in the input stage, then written into the result queue,
// whose head drives the result port; the request waits while the queue lacks room.
// Throughput: one request per cycle while each yields one word and the queue has room;
// a draw plus a scroll gives two words for the one-word-per-cycle result port.
// Results pass a 4-entry queue, fed from the input stage while it holds at most 2 words.
// Reset (rst, synchronous): cursor to top-left, registers to 80x25 white on black,
// input stage and result queue emptied.
module text_console_cursor_engine_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       req_valid,
  output logic       req_stall,
  input  logic       operation,
  input  logic [7:0] char_code,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [1:0] action,
  output logic [7:0] col,
  output logic [7:0] row,
  output logic [7:0] glyph,
  output logic [3:0] glyph_fg,
  output logic [3:0] glyph_bg,
  output logic       accepted,
  output logic       last
);
  import tccu_pkg::*;

  cfg_t      cfg;
  step_out_t step;
  result_t   head;
  logic      in_full;
  logic      op_q;
  logic [7:0] ch_q;
  logic      room, advance, pop;

  assign cfg_ready = 1'b1;

  tccu_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign advance   = in_full && room;
  assign req_stall = in_full && !room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (req_valid && !req_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      op_q <= operation;
      ch_q <= char_code;
    end
  end

  tccu_step u_step (
    .clk       (clk),
    .rst       (rst),
    .go        (advance),
    .operation (op_q),
    .char_code (ch_q),
    .cfg       (cfg),
    .step      (step)
  );

  assign pop = res_valid && !res_stall;

  tccu_res_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .pop       (pop),
    .room      (room),
    .not_empty (res_valid),
    .head      (head)
  );

  assign action   = head.action;
  assign col      = head.col;
  assign row      = head.row;
  assign glyph    = head.glyph;
  assign glyph_fg = head.glyph_fg;
  assign glyph_bg = head.glyph_bg;
  assign accepted = head.accepted;
  assign last     = head.last;

endmodule

@@ rtl/core/tccu_cfg_regs.sv @@
// Configuration register file: screen size and drawing colors.
module tccu_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic [7:0]    wr_index,
  input  logic [7:0]    wr_data,
  output tccu_pkg::cfg_t cfg
);
  import tccu_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.columns  <= COLUMNS_RESET;
      cfg.rows     <= ROWS_RESET;
      cfg.fg_color <= FG_COLOR_RESET;
      cfg.bg_color <= BG_COLOR_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_COLUMNS:  cfg.columns  <= wr_data;
        REG_ROWS:     cfg.rows     <= wr_data;
        REG_FG_COLOR: cfg.fg_color <= wr_data[3:0];
        REG_BG_COLOR: cfg.bg_color <= wr_data[3:0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/core/tccu_step.sv @@
// Cursor state and the single-pass logic that turns one request into screen actions.
module tccu_step (
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  logic               operation,
  input  logic [7:0]         char_code,
  input  tccu_pkg::cfg_t     cfg,
  output tccu_pkg::step_out_t step
);
  import tccu_pkg::*;

  logic [7:0] cursor_col, cursor_row;
  logic [7:0] cursor_col_next, cursor_row_next;
  logic [7:0] last_col, last_row;
  logic [7:0] c, r;
  result_t    blank;

  // zero dimension behaves as one
  assign last_col = (cfg.columns == 8'd0) ? 8'd0 : cfg.columns - 8'd1;
  assign last_row = (cfg.rows == 8'd0) ? 8'd0 : cfg.rows - 8'd1;

  // clamp a cursor left off screen by a shrink
  assign c = (cursor_col > last_col) ? last_col : cursor_col;
  assign r = (cursor_row > last_row) ? last_row : cursor_row;

  always_comb begin
    blank           = '0;
    blank.action    = ACT_NONE;
    blank.accepted  = 1'b1;
    step.push       = go;
    step.two        = 1'b0;
    step.first      = blank;
    step.second     = blank;
    step.second.action = ACT_SCROLL;
    step.second.last   = 1'b1;
    cursor_col_next = c;
    cursor_row_next = r;

    if (operation == OP_CLEAR) begin
      cursor_col_next    = 8'd0;
      cursor_row_next    = 8'd0;
      step.first.action  = ACT_CLEAR;
    end else if (char_code == CH_NEWLINE) begin
      cursor_col_next = 8'd0;
      if (r == last_row) begin
        step.first.action = ACT_SCROLL;
      end else begin
        cursor_row_next = r + 8'd1;
      end
    end else if (char_code == CH_BACKSPACE) begin
      if (c == 8'd0 && r == 8'd0) begin
        step.first.accepted = 1'b0;
      end else begin
        if (c == 8'd0) begin
          cursor_row_next = r - 8'd1;
          cursor_col_next = last_col;
        end else begin
          cursor_col_next = c - 8'd1;
        end
        step.first.action   = ACT_DRAW;
        step.first.col      = cursor_col_next;
        step.first.row      = cursor_row_next;
        step.first.glyph    = CH_SPACE;
        step.first.glyph_fg = cfg.fg_color;
        step.first.glyph_bg = cfg.bg_color;
      end
    end else begin
      step.first.action   = ACT_DRAW;
      step.first.col      = c;
      step.first.row      = r;
      step.first.glyph    = char_code;
      step.first.glyph_fg = cfg.fg_color;
      step.first.glyph_bg = cfg.bg_color;
      if (c == last_col) begin
        cursor_col_next = 8'd0;
        if (r == last_row) begin
          step.two = 1'b1;
        end else begin
          cursor_row_next = r + 8'd1;
        end
      end else begin
        cursor_col_next = c + 8'd1;
      end
    end
    step.first.last = !step.two;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col <= 8'd0;
      cursor_row <= 8'd0;
    end else if (go) begin
      cursor_col <= cursor_col_next;
      cursor_row <= cursor_row_next;
    end
  end

endmodule

@@ rtl/core/tccu_res_queue.sv @@
// Result queue: takes one or two words per cycle, hands out one word per cycle on pop.
module tccu_res_queue (
  input  logic                clk,
  input  logic                rst,
  input  tccu_pkg::step_out_t step,
  input  logic                pop,
  output logic                room,
  output logic                not_empty,
  output tccu_pkg::result_t   head
);
  import tccu_pkg::*;

  result_t                 mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]       wptr, rptr;
  logic [QPTR_W:0]         count, count_next;
  logic [QPTR_W:0]         n_push;

  assign n_push    = step.push ? (step.two ? (QPTR_W+1)'(2) : (QPTR_W+1)'(1))
                               : '0;
  assign room      = count <= (QPTR_W+1)'(QUEUE_DEPTH - 2);
  assign not_empty = count != '0;
  assign head      = mem[rptr];
  assign count_next = count + n_push - {{QPTR_W{1'b0}}, pop};

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + n_push[QPTR_W-1:0];
      count <= count_next;
      if (pop) begin
        rptr <= rptr + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step.push) begin
      mem[wptr] <= step.first;
      if (step.two) begin
        mem[wptr + QPTR_W'(1)] <= step.second;
      end
    end
  end

endmodule

@@ rtl/core/tccu_checker.sv @@
// Port-level checks for the cursor engine, bound to the top level.
module tccu_checker (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_stall,
  input logic [1:0] action,
  input logic [7:0] col,
  input logic [7:0] row,
  input logic [7:0] glyph,
  input logic       accepted,
  input logic       last
);
  import tccu_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(action) && $stable(col) &&
                               $stable(row) && $stable(glyph) && $stable(last))
    else $error("stalled result word changed");

  a_refused: assert property (@(posedge clk) disable iff (rst)
    res_valid && !accepted |-> action == ACT_NONE && last)
    else $error("refused request must give a single no-op word");

  a_nondraw: assert property (@(posedge clk) disable iff (rst)
    res_valid && action != ACT_DRAW |-> col == 8'd0 && row == 8'd0 && glyph == 8'd0)
    else $error("non-draw word carries cell data");

  a_scroll_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && (action == ACT_SCROLL || action == ACT_CLEAR) |-> last)
    else $error("scroll or clear must end its request");

endmodule

bind text_console_cursor_engine_unit tccu_checker u_tccu_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .action    (action),
  .col       (col),
  .row       (row),
  .glyph     (glyph),
  .accepted  (accepted),
  .last      (last)
);

@@ bench/tb_text_console_cursor_engine_unit.sv @@
// Self-checking bench for the text console cursor engine: directed script, then random text.
`timescale 1ns / 1ps

module tb_text_console_cursor_engine_unit;
  import tccu_pkg::*;

  localparam int QUIET_LIMIT  = 3000;
  localparam int SETTLE_TAIL  = 4;
  localparam int BLOCK_CHARS  = 110;
  localparam int BLOCKS       = 5;
  localparam int IDLE_MODES   = 3;

  localparam result_t NO_WORD     = '0;
  localparam result_t W_REFUSED   = '{ACT_NONE, 8'd0, 8'd0, 8'd0, 4'd0, 4'd0, 1'b0, 1'b1};
  localparam result_t W_NO_CHANGE = '{ACT_NONE, 8'd0, 8'd0, 8'd0, 4'd0, 4'd0, 1'b1, 1'b1};
  localparam result_t W_SCROLLED  = '{ACT_SCROLL, 8'd0, 8'd0, 8'd0, 4'd0, 4'd0, 1'b1, 1'b1};
  localparam result_t W_CLEARED   = '{ACT_CLEAR, 8'd0, 8'd0, 8'd0, 4'd0, 4'd0, 1'b1, 1'b1};
  localparam result_t W_FIRST_A   = '{ACT_DRAW, 8'd0, 8'd0, 8'd65, FG_COLOR_RESET,
                                      BG_COLOR_RESET, 1'b1, 1'b1};

  typedef struct packed {
    logic       is_cfg;
    logic [7:0] reg_idx;
    logic [7:0] reg_val;
    logic       op;
    logic [7:0] ch;
    logic       typed;
    result_t    want;
  } script_row_t;

  localparam int SCRIPT_LEN = 32;
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{1'b0, 8'd0, 8'd0, OP_WRITE, CH_BACKSPACE, 1'b1, W_REFUSED},   // top-left, refused
    '{1'b0, 8'd0, 8'd0, OP_WRITE, 8'd65, 1'b1, W_FIRST_A},
    '{1'b0, 8'd0, 8'd0, OP_WRITE, CH_NEWLINE, 1'b1, W_NO_CHANGE},
    '{1'b0, 8'd0, 8'd0, OP_WRITE, 8'd0, 1'b0, NO_WORD},
    '{1'b0, 8'd0, 8'd0, OP_WRITE, 8'd255, 1'b0, NO_WORD},
    '{1'b0, 8'd0, 8'd0, OP_WRITE, CH_BACKSPACE, 1'b0, NO_WORD},
    '{1'b0, 8'd0, 8'd0, OP_CLEAR, 8'd255, 1'b1, W_CLEARED},
    '{1'b1, REG_COLUMNS, 8'd0, OP_WRITE, 8'd0, 1'b0, NO_WORD},    // zero width acts as one
    '{1'b1, REG_ROWS, 8'd2, OP_WRITE, 8'd0, 1'b0, NO_WORD},
    '{1'b1, REG_FG_COLOR, 8'd0, OP_WRITE, 8'd0, 1'b0, NO_WORD},
    '{1'b1, REG_BG_COLOR, 8'd15, OP_WRITE, 8'd0, 1'b0, NO_WORD},
    '{1'b0, 8'd0, 8'd0, OP_WRITE, 8'd120, 1'b0, NO_WORD},
    '{1'b0, 8'd0, 8'd0, OP_WRITE, 8'd121, 1'b0, NO_WORD},         // draw + scroll
    '{1'b0, 8'd0, 8'd0, OP_WRITE, CH_NEWLINE, 1'b1, W_SCROLLED},
    '{1'b0, 8'd0, 8'd0, OP_WRITE, CH_BACKSPACE, 1'b0, NO_WORD},    // wraps to previous row
    '{1'b0, 8'd0, 8'd0, OP_WRITE, CH_BACKSPACE, 1'b1, W_REFUSED},
    '{1'b1, REG_ROWS, 8'd0, OP_WRITE, 8'd0, 1'b0, NO_WORD},
    '{1'b0, 8'd0, 8'd0, OP_WRITE, 8'd122, 1'b0, NO_WORD},
    '{1'b1, REG_COLUMNS, 8'd255, OP_WRITE, 8'd0, 1'b0, NO_WORD},
    '{1'b1, REG_ROWS, 8'd255, OP_WRITE, 8'd0, 1'b0, NO_WORD},
    '{1'b1, REG_FG_COLOR, 8'd15, OP_WRITE, 8'd0, 1'b0, NO_WORD},
    '{1'b1, REG_BG_COLOR, 8'd0, OP_WRITE, 8'd0, 1'b0, NO_WORD},
    '{1'b0, 8'd0, 8'd0, OP_WRITE, CH_NEWLINE, 1'b0, NO_WORD},
    '{1'b0, 8'd0, 8'd0, OP_WRITE, CH_NEWLINE, 1'b0, NO_WORD},
    '{1'b0, 8'd0, 8'd0, OP_WRITE, 8'd97, 1'b0, NO_WORD},
    '{1'b0, 8'd0, 8'd0, OP_WRITE, 8'd98, 1'b0, NO_WORD},
    '{1'b0, 8'd0, 8'd0, OP_WRITE, 8'd99, 1'b0, NO_WORD},
    '{1'b1, REG_COLUMNS, 8'd3, OP_WRITE, 8'd0, 1'b0, NO_WORD},    // shrink under the cursor
    '{1'b1, REG_ROWS, 8'd1, OP_WRITE, 8'd0, 1'b0, NO_WORD},
    '{1'b0, 8'd0, 8'd0, OP_WRITE, 8'd100, 1'b0, NO_WORD},         // clamped, then scroll
    '{1'b0, 8'd0, 8'd0, OP_WRITE, CH_BACKSPACE, 1'b0, NO_WORD},
    '{1'b0, 8'd0, 8'd0, OP_CLEAR, 8'd0, 1'b1, W_CLEARED}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  logic       req_valid = 1'b0;
  logic       req_stall;
  logic       operation = OP_WRITE;
  logic [7:0] char_code = '0;
  logic       res_valid;
  logic       res_stall = 1'b0;
  logic [1:0] action;
  logic [7:0] col;
  logic [7:0] row;
  logic [7:0] glyph;
  logic [3:0] glyph_fg;
  logic [3:0] glyph_bg;
  logic       accepted;
  logic       last;

  text_console_cursor_engine_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .operation (operation),
    .char_code (char_code),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .action    (action),
    .col       (col),
    .row       (row),
    .glyph     (glyph),
    .glyph_fg  (glyph_fg),
    .glyph_bg  (glyph_bg),
    .accepted  (accepted),
    .last      (last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predicted screen state
  cfg_t       screen_cfg = '{COLUMNS_RESET, ROWS_RESET, FG_COLOR_RESET, BG_COLOR_RESET};
  logic [7:0] cur_col = '0;
  logic [7:0] cur_row = '0;
  result_t    screen_ops[$];

  logic       cur_typed = 1'b0;
  result_t    cur_typed_word = '0;
  int         send_idle = 34;
  int         recv_idle = 74;
  int         mismatch_count = 0;
  int         quiet_cycles = 0;

  // One character or clear against the predicted cursor; a draw may be followed by a scroll.
  task automatic advance_cursor(input logic op_in, input logic [7:0] ch_in,
                                output result_t first, output result_t second,
                                output logic two);
    int ncol;
    int nrow;
    ncol   = (screen_cfg.columns == 0) ? 1 : int'(screen_cfg.columns);
    nrow   = (screen_cfg.rows == 0) ? 1 : int'(screen_cfg.rows);
    first  = '0;
    second = '0;
    two    = 1'b0;
    first.accepted  = 1'b1;
    second.accepted = 1'b1;
    second.action   = ACT_SCROLL;
    if (op_in == OP_CLEAR) begin
      cur_col = '0;
      cur_row = '0;
      first.action = ACT_CLEAR;
    end else begin
      if (int'(cur_col) >= ncol) cur_col = 8'(ncol - 1);
      if (int'(cur_row) >= nrow) cur_row = 8'(nrow - 1);
      if (ch_in == CH_NEWLINE) begin
        cur_col = '0;
        if (int'(cur_row) + 1 >= nrow) begin
          first.action = ACT_SCROLL;
        end else begin
          cur_row = cur_row + 8'd1;
          first.action = ACT_NONE;
        end
      end else if (ch_in == CH_BACKSPACE) begin
        if (cur_col == 0 && cur_row == 0) begin
          first.action   = ACT_NONE;
          first.accepted = 1'b0;
        end else begin
          if (cur_col == 0) begin
            cur_row = cur_row - 8'd1;
            cur_col = 8'(ncol - 1);
          end else begin
            cur_col = cur_col - 8'd1;
          end
          first = '{ACT_DRAW, cur_col, cur_row, CH_SPACE, screen_cfg.fg_color,
                    screen_cfg.bg_color, 1'b1, 1'b0};
        end
      end else begin
        first = '{ACT_DRAW, cur_col, cur_row, ch_in, screen_cfg.fg_color,
                  screen_cfg.bg_color, 1'b1, 1'b0};
        if (int'(cur_col) + 1 >= ncol) begin
          cur_col = '0;
          if (int'(cur_row) + 1 >= nrow) two = 1'b1;
          else cur_row = cur_row + 8'd1;
        end else begin
          cur_col = cur_col + 8'd1;
        end
      end
    end
    if (two) second.last = 1'b1;
    else first.last = 1'b1;
  endtask

  task automatic check_word(input result_t want, input result_t got);
    if (got.action !== want.action) begin
      $error("action: expected %0d, got %0d", want.action, got.action);
      mismatch_count++;
    end
    if (got.col !== want.col) begin
      $error("col: expected %0d, got %0d", want.col, got.col);
      mismatch_count++;
    end
    if (got.row !== want.row) begin
      $error("row: expected %0d, got %0d", want.row, got.row);
      mismatch_count++;
    end
    if (got.glyph !== want.glyph) begin
      $error("glyph: expected %0d, got %0d", want.glyph, got.glyph);
      mismatch_count++;
    end
    if (got.glyph_fg !== want.glyph_fg) begin
      $error("glyph_fg: expected %0d, got %0d", want.glyph_fg, got.glyph_fg);
      mismatch_count++;
    end
    if (got.glyph_bg !== want.glyph_bg) begin
      $error("glyph_bg: expected %0d, got %0d", want.glyph_bg, got.glyph_bg);
      mismatch_count++;
    end
    if (got.accepted !== want.accepted) begin
      $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
      mismatch_count++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0d, got %0d", want.last, got.last);
      mismatch_count++;
    end
  endtask

  // Watch all three channels at each edge: registers, requests, result words.
  always @(posedge clk) begin
    result_t w_first;
    result_t w_second;
    result_t got;
    logic    w_two;
    logic    moved;
    moved = 1'b0;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        moved = 1'b1;
        case (cfg_index)
          REG_COLUMNS:  screen_cfg.columns  = cfg_data;
          REG_ROWS:     screen_cfg.rows     = cfg_data;
          REG_FG_COLOR: screen_cfg.fg_color = cfg_data[3:0];
          REG_BG_COLOR: screen_cfg.bg_color = cfg_data[3:0];
          default: ;
        endcase
      end
      if (req_valid && !req_stall) begin
        moved = 1'b1;
        advance_cursor(operation, char_code, w_first, w_second, w_two);
        if (cur_typed) begin
          screen_ops.push_back(cur_typed_word);
        end else begin
          screen_ops.push_back(w_first);
          if (w_two) screen_ops.push_back(w_second);
        end
      end
      if (res_valid && !res_stall) begin
        moved = 1'b1;
        got = '{action, col, row, glyph, glyph_fg, glyph_bg, accepted, last};
        if (screen_ops.size() == 0) begin
          $error("result word with nothing expected: action %0d", action);
          mismatch_count++;
        end else begin
          check_word(screen_ops.pop_front(), got);
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    res_stall <= ($urandom_range(99) < recv_idle);
  end

  task automatic send_char(input logic op_in, input logic [7:0] ch_in,
                           input logic typed_in, input result_t want_in);
    while ($urandom_range(99) < send_idle) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid      <= 1'b1;
    operation      <= op_in;
    char_code      <= ch_in;
    cur_typed      <= typed_in;
    cur_typed_word <= want_in;
    do @(posedge clk); while (req_stall);
  endtask

  // Stop sending and let every pending word come out.
  task automatic settle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (screen_ops.size() != 0) @(posedge clk);
    repeat (SETTLE_TAIL) @(posedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_dim();
    case ($urandom_range(9))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd255;
      3, 4: return 8'($urandom_range(255, 1));
      default: return 8'($urandom_range(8, 1));
    endcase
  endfunction

  initial begin
    logic       op_pick;
    logic [7:0] ch_pick;
    int         roll;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (SCRIPT[i]) begin
      if (SCRIPT[i].is_cfg) write_reg(SCRIPT[i].reg_idx, SCRIPT[i].reg_val);
      else send_char(SCRIPT[i].op, SCRIPT[i].ch, SCRIPT[i].typed, SCRIPT[i].want);
    end

    for (int mode = 0; mode < IDLE_MODES; mode++) begin
      case (mode)
        0: begin
          send_idle = 34;
          recv_idle = 74;
        end
        1: begin
          send_idle = 74;
          recv_idle = 34;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      for (int blk = 0; blk < BLOCKS; blk++) begin
        write_reg(REG_COLUMNS, pick_dim());
        write_reg(REG_ROWS, pick_dim());
        write_reg(REG_FG_COLOR, 8'($urandom_range(15)));
        write_reg(REG_BG_COLOR, 8'($urandom_range(15)));
        for (int k = 0; k < BLOCK_CHARS; k++) begin
          roll    = $urandom_range(99);
          op_pick = OP_WRITE;
          ch_pick = 8'($urandom_range(255));
          if (roll < 3) op_pick = OP_CLEAR;
          else if (roll < 18) ch_pick = CH_NEWLINE;
          else if (roll < 36) ch_pick = CH_BACKSPACE;
          send_char(op_pick, ch_pick, 1'b0, NO_WORD);
        end
      end
    end

    settle();
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ text_console_cursor_engine_unit.f @@
rtl/core/tccu_pkg.sv
rtl/core/tccu_cfg_regs.sv
rtl/core/tccu_step.sv
rtl/core/tccu_res_queue.sv
rtl/core/text_console_cursor_engine_unit.sv
rtl/core/tccu_checker.sv
bench/tb_text_console_cursor_engine_unit.sv
